FILE: hw/rtl/lphs_pkg.sv
// Package for the linear probing hash set: sizes, mix constants, operation codes, control structs.
`timescale 1ns / 1ps
`default_nettype none
package lphs_pkg;

	localparam int TABLE_BITS = 10;
	localparam int SLOT_COUNT = 1 << TABLE_BITS;

	localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
	localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

	localparam logic [3:0] TABLE_BITS_RESET = 4'd10;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;   // input transfer: capture operation, first multiply
		logic mix;    // second multiply, form home slot
		logic rd;     // read slot at probe index
		logic cmp;    // evaluate slot read, step probe
		logic sweep;  // zero one slot of the clearing pass
	} lphs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_clear;    // input kind is clear
		logic in_probe;    // input is insert or lookup of a nonzero key
		logic hit;         // slot read holds the key
		logic empty;       // slot read is empty
		logic last_probe;  // slot read is the last of a full pass
		logic sweep_last;  // clearing pass at its last slot
	} lphs_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lphs_ctrl.sv
// Controller state machine for the linear probing hash set.
`timescale 1ns / 1ps
`default_nettype none
module lphs_ctrl import lphs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire lphs_stat_t stat,
	output lphs_cmd_t       cmd,
	output logic            busy,
	output logic            done
);

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_MIX   = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_CLEAR = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;
	logic   probe_end;

	assign probe_end = stat.hit || stat.empty || stat.last_probe;

	always_comb begin
		state_d   = state_q;
		done_d    = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (stat.in_clear) begin
						state_d = ST_CLEAR;
					end else if (stat.in_probe) begin
						state_d = ST_MIX;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				if (probe_end) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	a_read_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_CMP)
		else $error("slot read not followed by compare");

	a_probe_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && probe_end) |=> (done_q && state_q == ST_IDLE))
		else $error("finished probe gave no result");

	a_no_done_from_init: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) != ST_INIT && $past(state_q) != ST_MIX
			&& $past(state_q) != ST_READ))
		else $error("result strobe from a state that cannot end an operation");

endmodule
`default_nettype wire

FILE: hw/rtl/lphs_dp.sv
// Datapath for the linear probing hash set: key mix, probe index, slot memory, result registers.
`timescale 1ns / 1ps
`default_nettype none
module lphs_dp import lphs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lphs_cmd_t   cmd,
	output lphs_stat_t       stat,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] key,
	input  wire logic        table_bits_we,
	input  wire logic [3:0]  table_bits,
	output logic             found,
	output logic             status
);

	logic [31:0] slot_mem [SLOT_COUNT];

	logic [3:0]            table_bits_q;
	logic [TABLE_BITS-1:0] clr_addr_q;
	logic [1:0]            kind_q;
	logic [31:0]           key_q;
	logic [31:0]           mul1_q;
	logic [TABLE_BITS-1:0] idx_q;
	logic [TABLE_BITS-1:0] count_q;
	logic [31:0]           rdata_q;
	logic                  found_q, status_q;

	logic [3:0]            bits_use;
	logic [TABLE_BITS-1:0] mask;
	logic [31:0]           mix0, mix1, mul2, mix2;
	logic                  is_insert;
	logic                  wr_en;
	logic [TABLE_BITS-1:0] wr_addr;
	logic [31:0]           wr_data;

	always_comb begin
		if (table_bits_q < 4'd2) begin
			bits_use = 4'd2;
		end else if (table_bits_q > 4'(TABLE_BITS)) begin
			bits_use = 4'(TABLE_BITS);
		end else begin
			bits_use = table_bits_q;
		end
		for (int i = 0; i < TABLE_BITS; i++) begin
			mask[i] = (i < int'(bits_use));
		end
	end

	assign mix0 = key ^ (key >> 16);
	assign mix1 = mul1_q ^ (mul1_q >> 15);
	assign mul2 = mix1 * MIX_MUL_B;
	assign mix2 = mul2 ^ (mul2 >> 16);

	assign is_insert = (kind_q == KIND_INSERT);

	assign stat.in_clear   = (kind == KIND_CLEAR);
	assign stat.in_probe   = (kind == KIND_INSERT || kind == KIND_LOOKUP) && (key != '0);
	assign stat.hit        = (rdata_q == key_q);
	assign stat.empty      = (rdata_q == '0);
	assign stat.last_probe = (count_q == mask);
	assign stat.sweep_last = &clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_bits_q <= TABLE_BITS_RESET;
			clr_addr_q   <= '0;
		end else begin
			if (table_bits_we) table_bits_q <= table_bits;
			if (cmd.sweep) clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			key_q    <= key;
			mul1_q   <= mix0 * MIX_MUL_A;
			found_q  <= 1'b0;
			status_q <= 1'b0;
		end
		if (cmd.mix) begin
			idx_q   <= mix2[TABLE_BITS-1:0] & mask;
			count_q <= '0;
		end
		if (cmd.cmp) begin
			idx_q   <= (idx_q + 1'b1) & mask;
			count_q <= count_q + 1'b1;
			if (stat.hit) begin
				found_q <= 1'b1;
			end else if (!stat.empty && stat.last_probe && is_insert) begin
				status_q <= 1'b1;
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = key_q;
		if (cmd.sweep) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (cmd.cmp && stat.empty && is_insert) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_mem[wr_addr] <= wr_data;
		if (cmd.rd) rdata_q <= slot_mem[idx_q];
	end

	assign found  = found_q;
	assign status = status_q;

	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cmp && status_q) |-> (kind_q == KIND_INSERT))
		else $error("full status on an operation other than insert");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> ((idx_q & ~mask) == '0))
		else $error("probe index outside the slots in use");

endmodule
`default_nettype wire

FILE: hw/rtl/linear_probing_hash_set.sv
// Top level of the linear probing hash set: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Hash set of nonzero 32-bit keys in a table of 2**table_bits slots (2..10, reset 10).
// An operation is taken when start is high and busy is low; its one result (found, status)
// is on the ports when done is high and must be captured then; found and status keep it
// until the next operation is taken. After reset the block runs a clearing pass over all
// 1024 slots, one slot a cycle, with busy high; table_bits may be written meanwhile.
// A clear keeps busy high while it sweeps all 1024 slots and gives its result the cycle after.
// Insert and lookup mix the key with two multiplies, one at the transfer and one in the mix
// state, then probe one slot after another, each with a slot memory read and then a compare;
// a no-op (key zero, unused kind) gives its result the cycle after transfer.
module linear_probing_hash_set import lphs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] key,
	output logic             busy,
	output logic             done,
	output logic             found,
	output logic             status,
	input  wire logic        table_bits_we,
	input  wire logic [3:0]  table_bits
);

	lphs_cmd_t  cmd;
	lphs_stat_t stat;

	lphs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lphs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (kind),
		.key           (key),
		.table_bits_we (table_bits_we),
		.table_bits    (table_bits),
		.found         (found),
		.status        (status)
	);

endmodule
`default_nettype wire
